[hdl/ufp_pkg.sv]
// ufp_pkg: shared constants, codes and types of the uart frame parser
// no dependencies; used by every module of the block

package ufp_pkg;

	// frame layout
	localparam int MaxPayload = 16;
	localparam int StoreAw    = $clog2(MaxPayload);
	localparam int CountW     = $clog2(MaxPayload + 1);
	localparam logic [7:0] HdrByte = 8'hB7;
	localparam logic [7:0] TrlByte = 8'h98;

	// configuration register indexes
	localparam logic RegPickupEnable = 1'b0;

	// parser phases
	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_COUNT = 2'd1,
		PH_DATA  = 2'd2,
		PH_TRAIL = 2'd3
	} phase_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_CONSUME = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_REJECT  = 2'd2
	} kind_t;

	// parser verdict on the current byte plus store read data
	typedef struct packed {
		kind_t             kind;
		logic [CountW-1:0] count;
		logic [7:0]        data;
	} ufp_res_t;

endpackage

[hdl/ufp_parser.sv]
// ufp_parser: frame parsing state and the payload byte store
// depends on ufp_pkg

module ufp_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [7:0]                   rx_byte,
	input  logic [ufp_pkg::StoreAw-1:0]  rd_addr,
	output ufp_pkg::ufp_res_t            res
);

	ufp_pkg::phase_t             phase_q, phase_d;
	logic [ufp_pkg::CountW-1:0]  cnt_q, cnt_d;
	logic [ufp_pkg::CountW-1:0]  idx_q, idx_d;
	logic [ufp_pkg::CountW-1:0]  idx_inc;
	logic [7:0]                  store_q [ufp_pkg::MaxPayload];
	logic                        store_wr;
	logic                        store_clr;
	logic                        cnt_ok;

	assign idx_inc = idx_q + ufp_pkg::CountW'(1);
	assign cnt_ok  = (rx_byte >= 8'd1) && (rx_byte <= 8'(ufp_pkg::MaxPayload));

	// next state of the frame sequencer
	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		store_wr  = 1'b0;
		store_clr = 1'b0;
		case (phase_q)
			ufp_pkg::PH_HUNT: begin
				if (rx_byte == ufp_pkg::HdrByte)
					phase_d = ufp_pkg::PH_COUNT;
			end
			ufp_pkg::PH_COUNT: begin
				if (cnt_ok) begin
					cnt_d   = ufp_pkg::CountW'(rx_byte);
					idx_d   = '0;
					phase_d = ufp_pkg::PH_DATA;
				end else begin
					phase_d = ufp_pkg::PH_HUNT;
				end
			end
			ufp_pkg::PH_DATA: begin
				if (rx_byte == ufp_pkg::TrlByte) begin
					idx_d = '0;
				end else begin
					store_wr = (idx_q < ufp_pkg::CountW'(ufp_pkg::MaxPayload));
					idx_d    = idx_inc;
					if (idx_inc >= cnt_q)
						phase_d = ufp_pkg::PH_TRAIL;
				end
			end
			ufp_pkg::PH_TRAIL: begin
				phase_d   = ufp_pkg::PH_HUNT;
				idx_d     = '0;
				store_clr = (rx_byte != ufp_pkg::TrlByte);
			end
			default: phase_d = ufp_pkg::PH_HUNT;
		endcase
	end

	// verdict for the byte at hand
	always_comb begin
		res.kind  = ufp_pkg::KIND_CONSUME;
		res.count = cnt_q;
		res.data  = store_q[rd_addr];
		if (phase_q == ufp_pkg::PH_TRAIL) begin
			if (rx_byte == ufp_pkg::TrlByte)
				res.kind = ufp_pkg::KIND_PAYLOAD;
			else
				res.kind = ufp_pkg::KIND_REJECT;
		end
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ufp_pkg::PH_HUNT;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
		end
	end

	// payload store, cleared on reset and on a rejected frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ufp_pkg::MaxPayload; i++)
				store_q[i] <= '0;
		end else if (step && store_clr) begin
			for (int i = 0; i < ufp_pkg::MaxPayload; i++)
				store_q[i] <= '0;
		end else if (step && store_wr) begin
			store_q[idx_q[ufp_pkg::StoreAw-1:0]] <= rx_byte;
		end
	end

endmodule

[hdl/ufp_emit.sv]
// ufp_emit: result register and the payload burst sequencer
// depends on ufp_pkg; reads the store through ufp_parser

module ufp_emit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  ufp_pkg::ufp_res_t            res,
	input  logic                         pickup_en,
	output logic [ufp_pkg::StoreAw-1:0]  rd_addr,
	output logic                         busy,
	output logic                         load_en,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   kind,
	output logic [3:0]                   byte_index,
	output logic [7:0]                   payload_byte,
	output logic                         last,
	output logic                         pickup
);

	logic                         out_valid_q;
	logic                         burst_q;
	logic [ufp_pkg::StoreAw-1:0]  emit_idx_q;
	ufp_pkg::kind_t               kind_q;
	logic [3:0]                   byte_index_q;
	logic [7:0]                   payload_q;
	logic                         last_q;
	logic                         pickup_q;
	logic                         burst_last;

	assign load_en    = !out_valid_q || out_ready;
	assign busy       = burst_q;
	assign rd_addr    = burst_q ? emit_idx_q : '0;
	assign burst_last = (ufp_pkg::CountW'(emit_idx_q) + ufp_pkg::CountW'(1)) == res.count;

	// control: valid flag and burst position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			burst_q     <= 1'b0;
			emit_idx_q  <= '0;
		end else if (step) begin
			out_valid_q <= 1'b1;
			burst_q     <= (res.kind == ufp_pkg::KIND_PAYLOAD) &&
			               (res.count != ufp_pkg::CountW'(1));
			emit_idx_q  <= ufp_pkg::StoreAw'(1);
		end else if (burst_q && load_en) begin
			out_valid_q <= 1'b1;
			burst_q     <= !burst_last;
			emit_idx_q  <= emit_idx_q + ufp_pkg::StoreAw'(1);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result beat fields
	always_ff @(posedge clk) begin
		if (step) begin
			kind_q <= res.kind;
			if (res.kind == ufp_pkg::KIND_PAYLOAD) begin
				byte_index_q <= '0;
				payload_q    <= res.data;
				last_q       <= (res.count == ufp_pkg::CountW'(1));
				pickup_q     <= pickup_en;
			end else begin
				byte_index_q <= '0;
				payload_q    <= '0;
				last_q       <= 1'b1;
				pickup_q     <= 1'b0;
			end
		end else if (burst_q && load_en) begin
			kind_q       <= ufp_pkg::KIND_PAYLOAD;
			byte_index_q <= 4'(emit_idx_q);
			payload_q    <= res.data;
			last_q       <= burst_last;
			pickup_q     <= pickup_en;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign byte_index   = byte_index_q;
	assign payload_byte = payload_q;
	assign last         = last_q;
	assign pickup       = pickup_q;

endmodule

[hdl/uart_frame_parser_unit.sv]
// uart_frame_parser_unit: top level of the header/count/trailer frame parser
// depends on ufp_pkg, ufp_parser, ufp_emit
//
// Usage:
// - input channel (in_valid/in_ready, rx_byte) takes one received byte per beat
// - output channel (out_valid/out_ready) gives kind, byte_index, payload_byte,
//   last and pickup; every input byte yields one beat, except a valid trailer,
//   which yields one beat per stored payload byte, the final one with last set
// - an input register feeds the parser; results come from a result register
// - throughput is one byte per cycle while out_ready stays high and no burst
//   runs; after the trailer of a frame the parser holds while the burst drains
//   from the 16-entry store, and the input register can still take one more
//   byte then
// - when out_ready is low the result register holds and the input register
//   takes one byte, then in_ready drops until the receiver moves again
// - pickup_enable sits at APB address 0; the user must write it only while idle, the block does not enforce this
// - reset clears the parser to header hunting, empties both registers,
//   zeroes the payload store and clears pickup_enable

module uart_frame_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [3:0]  byte_index,
	output logic [7:0]  payload_byte,
	output logic        last,
	output logic        pickup,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                         valid_s1;
	logic [7:0]                   byte_s1;
	logic                         step;
	logic                         busy;
	logic                         load_en;
	logic                         pickup_en_q;
	logic [ufp_pkg::StoreAw-1:0]  rd_addr;
	ufp_pkg::ufp_res_t            res;

	// input register advance
	assign step     = valid_s1 && !busy && load_en;
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			byte_s1 <= rx_byte;
	end

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pickup_en_q <= 1'b0;
		end else if (psel && penable && pwrite && pready &&
		             paddr[2] == ufp_pkg::RegPickupEnable) begin
			pickup_en_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == ufp_pkg::RegPickupEnable)
			prdata[0] = pickup_en_q;
	end

	// parser and result stage
	ufp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.rd_addr (rd_addr),
		.res     (res)
	);

	ufp_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.res          (res),
		.pickup_en    (pickup_en_q),
		.rd_addr      (rd_addr),
		.busy         (busy),
		.load_en      (load_en),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.byte_index   (byte_index),
		.payload_byte (payload_byte),
		.last         (last),
		.pickup       (pickup)
	);

endmodule

[hdl/ufp_checker.sv]
// ufp_checker: port-level assertions for the uart frame parser
// depends on ufp_pkg; bound to uart_frame_parser_unit

module ufp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [3:0]  byte_index,
	input logic [7:0]  payload_byte,
	input logic        last,
	input logic        pickup
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) &&
		$stable(byte_index) && $stable(payload_byte) && $stable(last) && $stable(pickup))
		else $error("result beat changed while stalled");

	// consumed and rejected beats are single, blank results
	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == ufp_pkg::KIND_CONSUME || kind == ufp_pkg::KIND_REJECT) |->
		last && !pickup && payload_byte == 8'd0 && byte_index == 4'd0)
		else $error("non-payload beat has stray fields");

	// payload burst runs back to back with rising index
	a_burst_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && kind == ufp_pkg::KIND_PAYLOAD && !last |=>
		out_valid && kind == ufp_pkg::KIND_PAYLOAD &&
		byte_index == $past(byte_index) + 4'd1)
		else $error("payload burst broken");

	// no undefined kind code
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind != 2'd3)
		else $error("undefined result kind");

endmodule

bind uart_frame_parser_unit ufp_checker u_ufp_checker (.*);

[sim/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: self-checking testbench of uart_frame_parser_unit, byte in, result beats out
// depends on ufp_pkg and the block's rtl; an in-bench frame parser predicts every beat

module tb_top;

	localparam int HalfPeriod = 10;
	localparam int LongHold   = 80;
	localparam int CycleLimit = 400000;
	localparam logic [2:0] PickupAddr = {ufp_pkg::RegPickupEnable, 2'b00};
	// no register lives behind this word, writes there must be dropped
	localparam logic [2:0] SpareAddr = 3'd4;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [3:0]  byte_index;
	logic [7:0]  payload_byte;
	logic        last;
	logic        pickup;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// one expected result beat
	typedef struct packed {
		ufp_pkg::kind_t kind;
		logic [3:0]     pos;
		logic [7:0]     data;
		logic           last;
		logic           pickup;
	} beat_t;

	// frame parser mirror plus the queue of beats still owed by the block
	class frame_checker;
		beat_t           due_beats[$];
		ufp_pkg::phase_t phase;
		logic [4:0]      count;
		logic [4:0]      fill;
		logic [7:0]      store [ufp_pkg::MaxPayload];
		logic            pickup_en;
		int              fails;
		int              frames;
		int              rejects;
		int              beats;

		function new();
			phase = ufp_pkg::PH_HUNT;
			count = 0;
			fill = 0;
			pickup_en = 0;
			foreach (store[i]) store[i] = 8'h00;
			fails = 0;
			frames = 0;
			rejects = 0;
			beats = 0;
		endfunction

		function void set_pickup(logic en);
			pickup_en = en;
		endfunction

		function int pending();
			return due_beats.size();
		endfunction

		function void queue_beat(ufp_pkg::kind_t k, logic [3:0] pos, logic [7:0] data,
				logic last, logic pickup);
			beat_t e;
			e.kind = k;
			e.pos = pos;
			e.data = data;
			e.last = last;
			e.pickup = pickup;
			due_beats.push_back(e);
		endfunction

		// advance the parser by one accepted byte
		function void take_byte(logic [7:0] b);
			case (phase)
				ufp_pkg::PH_HUNT: begin
					if (b == ufp_pkg::HdrByte) phase = ufp_pkg::PH_COUNT;
				end
				ufp_pkg::PH_COUNT: begin
					if (b >= 1 && b <= ufp_pkg::MaxPayload) begin
						count = b[4:0];
						fill = 0;
						phase = ufp_pkg::PH_DATA;
					end else begin
						phase = ufp_pkg::PH_HUNT;
					end
				end
				ufp_pkg::PH_DATA: begin
					// a trailer inside the payload restarts the index, store kept
					if (b == ufp_pkg::TrlByte) begin
						fill = 0;
					end else begin
						if (fill < ufp_pkg::MaxPayload) store[fill[3:0]] = b;
						fill++;
						if (fill >= count) phase = ufp_pkg::PH_TRAIL;
					end
				end
				default: begin
					phase = ufp_pkg::PH_HUNT;
					fill = 0;
					if (b == ufp_pkg::TrlByte) begin
						for (int k = 0; k < count; k++)
							queue_beat(ufp_pkg::KIND_PAYLOAD, 4'(k), store[k],
								(k + 1) == count, pickup_en);
						frames++;
					end else begin
						foreach (store[i]) store[i] = 8'h00;
						queue_beat(ufp_pkg::KIND_REJECT, 4'd0, 8'h00, 1'b1, 1'b0);
						rejects++;
					end
					return;
				end
			endcase
			queue_beat(ufp_pkg::KIND_CONSUME, 4'd0, 8'h00, 1'b1, 1'b0);
		endfunction

		function void compare(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				fails++;
			end
		endfunction

		// check one result beat against the oldest pending one
		function void match_beat(logic [1:0] k, logic [3:0] pos, logic [7:0] data,
				logic last, logic pickup);
			beat_t e;
			beats++;
			if (due_beats.size() == 0) begin
				$error("result beat with nothing pending: kind %0d index %0d", k, pos);
				fails++;
				return;
			end
			e = due_beats.pop_front();
			compare("kind", e.kind, k);
			compare("byte_index", e.pos, pos);
			compare("payload_byte", e.data, data);
			compare("last", e.last, last);
			compare("pickup", e.pickup, pickup);
		endfunction
	endclass

	frame_checker sb = new();
	int  cycles;
	int  bytes_in;
	bit  calm;
	bit  hold_req;
	int  stall_left;

	uart_frame_parser_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.byte_index   (byte_index),
		.payload_byte (payload_byte),
		.last         (last),
		.pickup       (pickup),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #HalfPeriod clk = ~clk;
	end

	// watchdog
	initial begin
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILED: results differ");
		$finish;
	end

	// gap length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	// payload content, a trailer value only once in a while
	function automatic logic [7:0] payload_rand();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == ufp_pkg::TrlByte && $urandom_range(0, 3) != 0) b = b ^ 8'h01;
		return b;
	endfunction

	// receiver side: random stalls plus one long hold on request
	initial begin
		out_ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall_left = LongHold - 1;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < 25) begin
				stall_left = gap_len();
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.match_beat(kind, byte_index, payload_byte, last, pickup);
	end

	task automatic idle_in(input int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// one input beat, after a random gap
	task automatic send_byte(input logic [7:0] b);
		idle_in(gap_len());
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		sb.take_byte(b);
		bytes_in++;
	endtask

	// header, count, payload and trailer; optionally a stray trailer mid-payload
	// or a wrong byte where the trailer belongs
	task automatic send_frame(input int n, input bit restart, input bit broken);
		int cut;
		logic [7:0] tail;
		cut = $urandom_range(0, n - 1);
		send_byte(ufp_pkg::HdrByte);
		send_byte(8'(n));
		if (restart) begin
			repeat (cut) send_byte(payload_rand());
			send_byte(ufp_pkg::TrlByte);
		end
		repeat (n) send_byte(payload_rand());
		tail = 8'($urandom_range(0, 255));
		if (tail == ufp_pkg::TrlByte) tail = ~tail;
		send_byte(broken ? tail : ufp_pkg::TrlByte);
	endtask

	// mostly good frames, some broken ones and some line noise
	task automatic random_traffic(input int target);
		int r;
		int n;
		while (bytes_in < target) begin
			r = $urandom_range(0, 99);
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, ufp_pkg::MaxPayload)
				: $urandom_range(1, 8);
			if (r < 70) begin
				send_frame(n, 1'b0, 1'b0);
			end else if (r < 80) begin
				send_frame(n, 1'b0, 1'b1);
			end else if (r < 86) begin
				send_frame(n, 1'b1, 1'b0);
			end else if (r < 93) begin
				send_byte(ufp_pkg::HdrByte);
				send_byte($urandom_range(0, 1) ? 8'h00
					: 8'($urandom_range(ufp_pkg::MaxPayload + 1, 255)));
			end else begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// stop sending and let every pending beat come out
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == PickupAddr) sb.set_pickup(data[0]);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// main sequence
	initial begin
		logic [7:0] opening [$];
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 3'd0;
		pwdata = 32'h0;
		calm = 1'b0;
		hold_req = 1'b0;
		bytes_in = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// noise, zero and too-large counts, a one-byte frame, a stray trailer
		// in the payload followed by a missing trailer
		opening = '{8'h00, ufp_pkg::HdrByte, 8'h00, ufp_pkg::HdrByte, 8'h11,
			ufp_pkg::HdrByte, 8'h01, 8'hFF, ufp_pkg::TrlByte,
			ufp_pkg::HdrByte, 8'h02, ufp_pkg::TrlByte, 8'h00, 8'h55, 8'h00, 8'hFF};
		foreach (opening[i]) send_byte(opening[i]);
		wait_idle();

		// ignored write to an empty slot, then pickup on
		reg_write(SpareAddr, 32'hFFFF_FFFF);
		reg_write(PickupAddr, 32'h0000_0001);

		// long receiver hold during a full-size frame, sender keeps going
		hold_req = 1'b1;
		send_frame(ufp_pkg::MaxPayload, 1'b0, 1'b0);
		random_traffic(bytes_in + 28);
		wait_idle();

		// only bit 0 counts: this turns pickup off
		reg_write(PickupAddr, 32'hFFFF_FFFE);
		calm = 1'b1;
		random_traffic(bytes_in + 28);
		wait_idle();

		calm = 1'b0;
		reg_write(PickupAddr, 32'h0000_0001);
		random_traffic(bytes_in + 28);
		wait_idle();
		repeat (8) @(posedge clk);

		$display("covered %0d bytes: %0d frames taken, %0d rejected, %0d beats checked",
			bytes_in, sb.frames, sb.rejects, sb.beats);
		$display("pickup flag exercised off and on, with stalls, a long hold and idle pauses");
		if (sb.fails == 0 && sb.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
